FILE: sv/cda_pkg.sv
`default_nettype none

package cda_pkg;

   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned DAY_W   = 5;
   localparam int unsigned AMT_W   = 16;
   localparam int unsigned STAT_W  = 2;

   localparam logic [YEAR_W-1:0]  MAX_YEAR        = 14'd9999;
   localparam logic [YEAR_W-1:0]  RESET_YEAR      = 14'd2000;
   localparam logic [MONTH_W-1:0] FIRST_MONTH     = 4'd1;
   localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
   localparam logic [DAY_W-1:0]   FIRST_DAY       = 5'd1;
   localparam logic [DAY_W-1:0]   LONG_MONTH_DAYS = 5'd31;
   localparam logic [DAY_W-1:0]   LEAP_FEB_DAYS   = 5'd29;
   localparam logic [DAY_W-1:0]   FEB_DAYS        = 5'd28;
   localparam logic [DAY_W-1:0]   SHORT_MONTH_DAYS = 5'd30;
   localparam logic [MONTH_W-1:0] MONTH_FEB       = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_APR       = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN       = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP       = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV       = 4'd11;

   // Reciprocals: floor(x*K/2^19) = x / 12 for x < 2^16, x / 100 for x < 2^14.
   localparam int unsigned RECIP_SHIFT = 19;
   localparam int unsigned QUO_W       = 13;
   localparam logic [AMT_W-1:0] RECIP_12  = 16'd43691;
   localparam logic [AMT_W-1:0] RECIP_100 = 16'd5243;

   typedef enum logic [1:0] {
      OP_SET_DATE   = 2'd0,
      OP_ADD_DAYS   = 2'd1,
      OP_ADD_MONTHS = 2'd2,
      OP_ADD_YEARS  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_INVALID  = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic {
      DIV_BY_100,
      DIV_BY_12
   } div_mode_type;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_SET_LEAP,
      SEQ_SET_FIN,
      SEQ_DAY_STEP,
      SEQ_MON_DIV,
      SEQ_MON_ADD,
      SEQ_YEAR_ADD,
      SEQ_WAIT_LEAP,
      SEQ_CLAMP
   } seq_state_type;

   // Days in a month; month codes outside 1..12 give 31 and are rejected elsewhere.
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (month) inside
         MONTH_FEB: len = leap ? LEAP_FEB_DAYS : FEB_DAYS;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = SHORT_MONTH_DAYS;
         default: len = LONG_MONTH_DAYS;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

FILE: sv/cda_div_unit.sv
`default_nettype none

// Shared divide-by-constant unit: one multiplier by a reciprocal, registered.
// In year mode the leap flag is derived from the registered quotient.
module cda_div_unit (
   input  wire logic                                clock,
   input  wire logic [cda_pkg::AMT_W-1:0]           opnd,
   input  wire cda_pkg::div_mode_type               mode,
   output logic      [cda_pkg::QUO_W-1:0]           quo,
   output logic                                     leap
);

   logic [cda_pkg::AMT_W-1:0]    recip;
   logic [2*cda_pkg::AMT_W-1:0]  prod;
   logic [cda_pkg::QUO_W-1:0]    quo_ff, quo_in;
   logic [cda_pkg::YEAR_W-1:0]   opnd_ff, opnd_in;
   logic [19:0]                  hundreds;
   logic [19:0]                  rem;

   always_comb begin
      recip   = (mode == cda_pkg::DIV_BY_12) ? cda_pkg::RECIP_12 : cda_pkg::RECIP_100;
      prod    = (2*cda_pkg::AMT_W)'(opnd) * (2*cda_pkg::AMT_W)'(recip);
      quo_in  = prod[cda_pkg::RECIP_SHIFT +: cda_pkg::QUO_W];
      opnd_in = opnd[cda_pkg::YEAR_W-1:0];
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      opnd_ff <= opnd_in;
   end

   // Divisible by 4, and not by 100 unless also by 400.
   always_comb begin
      hundreds = 20'(quo_ff) * 20'd100;
      rem      = 20'(opnd_ff) - hundreds;
      leap     = (opnd_ff[1:0] == 2'b00) && ((rem != 20'd0) || (quo_ff[1:0] == 2'b00));
      quo      = quo_ff;
   end

endmodule

`default_nettype wire

FILE: sv/calendar_date_adder.sv
// Throughput: one word at a time; busy stays high until the result strobe.
// Add days walks one month per cycle through one compare, once per month boundary
// crossed.
// Reset (synchronous, active high) loads 2000-01-01 and holds busy high.
// rsp_valid pulses for one cycle per word; the receiver cannot stall.
`default_nettype none

module calendar_date_adder (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [1:0]                        req_opcode,
   input  wire logic [cda_pkg::YEAR_W-1:0]        req_new_year,
   input  wire logic [cda_pkg::MONTH_W-1:0]       req_new_month,
   input  wire logic [cda_pkg::DAY_W-1:0]         req_new_day,
   input  wire logic [cda_pkg::AMT_W-1:0]         req_amount,
   output logic                                   rsp_valid,
   output logic      [cda_pkg::YEAR_W-1:0]        rsp_cur_year,
   output logic      [cda_pkg::MONTH_W-1:0]       rsp_cur_month,
   output logic      [cda_pkg::DAY_W-1:0]         rsp_cur_day,
   output logic      [cda_pkg::STAT_W-1:0]        rsp_status
);

   // Sequencer and date state
   cda_pkg::seq_state_type state_ff, state_in;
   logic [cda_pkg::YEAR_W-1:0]  year_ff, year_in;
   logic [cda_pkg::MONTH_W-1:0] month_ff, month_in;
   logic [cda_pkg::DAY_W-1:0]   day_ff, day_in;
   cda_pkg::status_type         status_ff, status_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // Captured request
   logic [cda_pkg::AMT_W-1:0]   n_ff, n_in;
   logic [cda_pkg::YEAR_W-1:0]  nyr_ff, nyr_in;
   logic [cda_pkg::MONTH_W-1:0] nmo_ff, nmo_in;
   logic [cda_pkg::DAY_W-1:0]   nday_ff, nday_in;

   // Shared divider
   logic [cda_pkg::AMT_W-1:0]   div_opnd;
   cda_pkg::div_mode_type       div_mode;
   logic [cda_pkg::QUO_W-1:0]   quo;
   logic                        leap;

   // Datapath terms
   logic [cda_pkg::DAY_W-1:0]   len_cur;
   logic [cda_pkg::DAY_W-1:0]   len_new;
   logic [cda_pkg::AMT_W:0]     day_sum;
   logic [cda_pkg::DAY_W-1:0]   day_used;
   logic [cda_pkg::AMT_W-1:0]   quo_x12;
   logic [cda_pkg::AMT_W-1:0]   mon_rem_full;
   logic [4:0]                  mon_idx;
   logic [4:0]                  mon_idx_adj;
   logic                        mon_carry;
   logic [cda_pkg::YEAR_W:0]    mon_year;
   logic [cda_pkg::AMT_W:0]     year_sum;
   logic                        set_ok;

   cda_div_unit u_div (
      .clock (clock),
      .opnd  (div_opnd),
      .mode  (div_mode),
      .quo   (quo),
      .leap  (leap)
   );

   assign busy = reset || (state_ff != cda_pkg::SEQ_IDLE);

   // Arithmetic shared by the sequencer states
   always_comb begin
      len_cur  = cda_pkg::month_len(month_ff, leap);
      len_new  = cda_pkg::month_len(nmo_ff, leap);
      day_sum  = (cda_pkg::AMT_W+1)'(day_ff) + (cda_pkg::AMT_W+1)'(n_ff);
      // Days consumed to reach the first of the next month
      day_used = len_cur - day_ff + cda_pkg::FIRST_DAY;

      // Months: split n into whole years (quo) and leftover months
      quo_x12      = cda_pkg::AMT_W'({quo, 3'b000}) + cda_pkg::AMT_W'({quo, 2'b00});
      mon_rem_full = n_ff - quo_x12;
      mon_idx      = 5'(month_ff) - 5'd1 + 5'(mon_rem_full[3:0]);
      mon_carry    = (mon_idx >= 5'(cda_pkg::MONTHS_PER_YEAR));
      mon_idx_adj  = mon_carry ? (mon_idx - 5'(cda_pkg::MONTHS_PER_YEAR)) : mon_idx;
      mon_year     = (cda_pkg::YEAR_W+1)'(year_ff) + (cda_pkg::YEAR_W+1)'(quo)
                     + (cda_pkg::YEAR_W+1)'(mon_carry);

      year_sum = (cda_pkg::AMT_W+1)'(year_ff) + (cda_pkg::AMT_W+1)'(n_ff);

      set_ok = (nyr_ff <= cda_pkg::MAX_YEAR)
               && (nmo_ff inside {[cda_pkg::FIRST_MONTH:cda_pkg::MONTHS_PER_YEAR]})
               && (nday_ff != 5'd0)
               && (nday_ff <= len_new);
   end

   // Next state and datapath control
   always_comb begin
      state_in     = state_ff;
      year_in      = year_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      status_in    = status_ff;
      rsp_valid_in = 1'b0;
      n_in         = n_ff;
      nyr_in       = nyr_ff;
      nmo_in       = nmo_ff;
      nday_in      = nday_ff;
      // Keep the leap flag tracking the current year unless the divider is claimed
      div_opnd     = cda_pkg::AMT_W'(year_ff);
      div_mode     = cda_pkg::DIV_BY_100;

      case (state_ff)
         cda_pkg::SEQ_IDLE: begin
            if (start) begin
               n_in    = req_amount;
               nyr_in  = req_new_year;
               nmo_in  = req_new_month;
               nday_in = req_new_day;
               case (cda_pkg::opcode_type'(req_opcode))
                  cda_pkg::OP_SET_DATE:   state_in = cda_pkg::SEQ_SET_LEAP;
                  cda_pkg::OP_ADD_DAYS:   state_in = cda_pkg::SEQ_DAY_STEP;
                  cda_pkg::OP_ADD_MONTHS: state_in = cda_pkg::SEQ_MON_DIV;
                  default:                state_in = cda_pkg::SEQ_YEAR_ADD;
               endcase
            end
         end

         cda_pkg::SEQ_SET_LEAP: begin
            // Look up the leap flag of the candidate year
            div_opnd = cda_pkg::AMT_W'(nyr_ff);
            state_in = cda_pkg::SEQ_SET_FIN;
         end

         cda_pkg::SEQ_SET_FIN: begin
            if (set_ok) begin
               year_in   = nyr_ff;
               month_in  = nmo_ff;
               day_in    = nday_ff;
               status_in = cda_pkg::STATUS_OK;
            end else begin
               status_in = cda_pkg::STATUS_INVALID;
            end
            rsp_valid_in = 1'b1;
            state_in     = cda_pkg::SEQ_IDLE;
         end

         cda_pkg::SEQ_DAY_STEP: begin
            if (day_sum <= (cda_pkg::AMT_W+1)'(len_cur)) begin
               day_in       = day_sum[cda_pkg::DAY_W-1:0];
               status_in    = cda_pkg::STATUS_OK;
               rsp_valid_in = 1'b1;
               state_in     = cda_pkg::SEQ_IDLE;
            end else begin
               // Use up the rest of this month and advance to the first of the next
               n_in   = n_ff - cda_pkg::AMT_W'(day_used);
               day_in = cda_pkg::FIRST_DAY;
               if (month_ff == cda_pkg::MONTHS_PER_YEAR) begin
                  if (year_ff >= cda_pkg::MAX_YEAR) begin
                     year_in      = cda_pkg::MAX_YEAR;
                     month_in     = cda_pkg::MONTHS_PER_YEAR;
                     day_in       = cda_pkg::LONG_MONTH_DAYS;
                     status_in    = cda_pkg::STATUS_OVERFLOW;
                     rsp_valid_in = 1'b1;
                     state_in     = cda_pkg::SEQ_IDLE;
                  end else begin
                     year_in  = year_ff + 14'd1;
                     month_in = cda_pkg::FIRST_MONTH;
                  end
               end else begin
                  month_in = month_ff + 4'd1;
               end
            end
         end

         cda_pkg::SEQ_MON_DIV: begin
            div_opnd = n_ff;
            div_mode = cda_pkg::DIV_BY_12;
            state_in = cda_pkg::SEQ_MON_ADD;
         end

         cda_pkg::SEQ_MON_ADD: begin
            if (mon_year > (cda_pkg::YEAR_W+1)'(cda_pkg::MAX_YEAR)) begin
               year_in      = cda_pkg::MAX_YEAR;
               month_in     = cda_pkg::MONTHS_PER_YEAR;
               day_in       = cda_pkg::LONG_MONTH_DAYS;
               status_in    = cda_pkg::STATUS_OVERFLOW;
               rsp_valid_in = 1'b1;
               state_in     = cda_pkg::SEQ_IDLE;
            end else begin
               year_in  = mon_year[cda_pkg::YEAR_W-1:0];
               month_in = cda_pkg::MONTH_W'(mon_idx_adj) + cda_pkg::FIRST_MONTH;
               state_in = cda_pkg::SEQ_WAIT_LEAP;
            end
         end

         cda_pkg::SEQ_YEAR_ADD: begin
            if (year_sum > (cda_pkg::AMT_W+1)'(cda_pkg::MAX_YEAR)) begin
               year_in      = cda_pkg::MAX_YEAR;
               month_in     = cda_pkg::MONTHS_PER_YEAR;
               day_in       = cda_pkg::LONG_MONTH_DAYS;
               status_in    = cda_pkg::STATUS_OVERFLOW;
               rsp_valid_in = 1'b1;
               state_in     = cda_pkg::SEQ_IDLE;
            end else begin
               year_in  = year_sum[cda_pkg::YEAR_W-1:0];
               state_in = cda_pkg::SEQ_WAIT_LEAP;
            end
         end

         cda_pkg::SEQ_WAIT_LEAP: begin
            // Let the divider pick up the leap flag of the new year
            state_in = cda_pkg::SEQ_CLAMP;
         end

         cda_pkg::SEQ_CLAMP: begin
            if (day_ff > len_cur) begin
               day_in = len_cur;
            end
            status_in    = cda_pkg::STATUS_OK;
            rsp_valid_in = 1'b1;
            state_in     = cda_pkg::SEQ_IDLE;
         end

         default: begin
            state_in = cda_pkg::SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cda_pkg::SEQ_IDLE;
         year_ff      <= cda_pkg::RESET_YEAR;
         month_ff     <= cda_pkg::FIRST_MONTH;
         day_ff       <= cda_pkg::FIRST_DAY;
         status_ff    <= cda_pkg::STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         year_ff      <= year_in;
         month_ff     <= month_in;
         day_ff       <= day_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      nyr_ff  <= nyr_in;
      nmo_ff  <= nmo_in;
      nday_ff <= nday_in;
   end

   // Drive the result word straight from the date state
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cur_year  = year_ff;
   assign rsp_cur_month = month_ff;
   assign rsp_cur_day   = day_ff;
   assign rsp_status    = status_ff;

   // The held date stays in range: year up to the maximum, month 1..12, day nonzero
   assert property (@(posedge clock) disable iff (reset)
      (year_ff <= cda_pkg::MAX_YEAR) && (month_ff >= cda_pkg::FIRST_MONTH)
      && (month_ff <= cda_pkg::MONTHS_PER_YEAR) && (day_ff != 5'd0))
      else $error("date state out of range");

   // A result ends the operation: the block is free in the strobe cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still busy");

   // One strobe per word: never two in a row
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe repeated");

   // An accepted word makes the block busy on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not start the sequencer");

   // Overflow always leaves the saturated date
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == cda_pkg::STATUS_OVERFLOW))
      |-> ((rsp_cur_year == cda_pkg::MAX_YEAR) && (rsp_cur_month == cda_pkg::MONTHS_PER_YEAR)
           && (rsp_cur_day == cda_pkg::LONG_MONTH_DAYS)))
      else $error("overflow without saturated date");

endmodule

`default_nettype wire

FILE: tb/calendar_date_adder_tb.sv
`timescale 1ns / 1ps

module calendar_date_adder_tb;

   // Worst case is the longest day walk plus sender gaps; allow several times over.
   localparam int unsigned CYCLE_LIMIT  = 3_000_000;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned WORDS_PER_PHASE = 82;

   // One result word: the date after the operation and its status.
   typedef struct packed {
      logic [cda_pkg::YEAR_W-1:0]  year;
      logic [cda_pkg::MONTH_W-1:0] month;
      logic [cda_pkg::DAY_W-1:0]   day;
      cda_pkg::status_type         status;
   } date_word_type;

   // One command word, with an optional hand-typed expectation.
   typedef struct {
      cda_pkg::opcode_type         op;
      logic [cda_pkg::YEAR_W-1:0]  year;
      logic [cda_pkg::MONTH_W-1:0] month;
      logic [cda_pkg::DAY_W-1:0]   day;
      logic [cda_pkg::AMT_W-1:0]   amount;
      bit                          known;
      date_word_type               want;
   } date_cmd_type;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic [1:0]                    req_opcode;
   logic [cda_pkg::YEAR_W-1:0]    req_new_year;
   logic [cda_pkg::MONTH_W-1:0]   req_new_month;
   logic [cda_pkg::DAY_W-1:0]     req_new_day;
   logic [cda_pkg::AMT_W-1:0]     req_amount;
   logic                          rsp_valid;
   logic [cda_pkg::YEAR_W-1:0]    rsp_cur_year;
   logic [cda_pkg::MONTH_W-1:0]   rsp_cur_month;
   logic [cda_pkg::DAY_W-1:0]     rsp_cur_day;
   logic [cda_pkg::STAT_W-1:0]    rsp_status;

   // Calendar state as the block should hold it.
   int unsigned cal_year;
   int unsigned cal_month;
   int unsigned cal_day;

   date_word_type pending_dates[$];
   date_cmd_type  directed_cmds[$];
   date_word_type oldest_date;
   int unsigned   error_count;
   int unsigned   cycle_count;

   calendar_date_adder u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_opcode    (req_opcode),
      .req_new_year  (req_new_year),
      .req_new_month (req_new_month),
      .req_new_day   (req_new_day),
      .req_amount    (req_amount),
      .rsp_valid     (rsp_valid),
      .rsp_cur_year  (rsp_cur_year),
      .rsp_cur_month (rsp_cur_month),
      .rsp_cur_day   (rsp_cur_day),
      .rsp_status    (rsp_status)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Full Gregorian rule: every 4th year, minus centuries, plus every 400th.
   function automatic bit leap_year(input int unsigned y);
      return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
   endfunction

   function automatic int unsigned days_of(input int unsigned y, input int unsigned m);
      int unsigned len;
      case (m)
         cda_pkg::MONTH_FEB:
            len = leap_year(y) ? cda_pkg::LEAP_FEB_DAYS : cda_pkg::FEB_DAYS;
         cda_pkg::MONTH_APR, cda_pkg::MONTH_JUN, cda_pkg::MONTH_SEP, cda_pkg::MONTH_NOV:
            len = cda_pkg::SHORT_MONTH_DAYS;
         default: len = cda_pkg::LONG_MONTH_DAYS;
      endcase
      return len;
   endfunction

   // Apply one command to the calendar state and return the date word it yields.
   function automatic date_word_type advance_calendar(input cda_pkg::opcode_type op,
                                                      input int unsigned ny,
                                                      input int unsigned nm,
                                                      input int unsigned nd,
                                                      input int unsigned amt);
      date_word_type       w;
      cda_pkg::status_type st;
      int unsigned         n;
      int unsigned         len;
      int unsigned         total;
      int unsigned         yy;
      bit                  done;
      bit                  sat;
      st  = cda_pkg::STATUS_OK;
      sat = 1'b0;
      case (op)
         cda_pkg::OP_SET_DATE: begin
            // Reject any impossible date and keep the old one.
            if (ny > cda_pkg::MAX_YEAR || nm < cda_pkg::FIRST_MONTH
                || nm > cda_pkg::MONTHS_PER_YEAR || nd < cda_pkg::FIRST_DAY)
               st = cda_pkg::STATUS_INVALID;
            else if (nd > days_of(ny, nm))
               st = cda_pkg::STATUS_INVALID;
            else begin
               cal_year  = ny;
               cal_month = nm;
               cal_day   = nd;
            end
         end
         cda_pkg::OP_ADD_DAYS: begin
            // Walk month by month, using up the days left in each.
            n    = amt;
            done = 1'b0;
            while (!done) begin
               len = days_of(cal_year, cal_month);
               if (cal_day + n <= len) begin
                  cal_day = cal_day + n;
                  done    = 1'b1;
               end else begin
                  n       = n - (len - cal_day + 1);
                  cal_day = cda_pkg::FIRST_DAY;
                  if (cal_month == cda_pkg::MONTHS_PER_YEAR) begin
                     if (cal_year >= cda_pkg::MAX_YEAR) begin
                        sat  = 1'b1;
                        done = 1'b1;
                     end else begin
                        cal_year  = cal_year + 1;
                        cal_month = cda_pkg::FIRST_MONTH;
                     end
                  end else begin
                     cal_month = cal_month + 1;
                  end
               end
            end
         end
         cda_pkg::OP_ADD_MONTHS: begin
            total = cal_year * cda_pkg::MONTHS_PER_YEAR + (cal_month - 1) + amt;
            yy    = total / cda_pkg::MONTHS_PER_YEAR;
            if (yy > cda_pkg::MAX_YEAR)
               sat = 1'b1;
            else begin
               cal_year  = yy;
               cal_month = total % cda_pkg::MONTHS_PER_YEAR + 1;
            end
         end
         default: begin
            yy = cal_year + amt;
            if (yy > cda_pkg::MAX_YEAR)
               sat = 1'b1;
            else
               cal_year = yy;
         end
      endcase
      if (sat) begin
         // Pin at the last representable day.
         cal_year  = cda_pkg::MAX_YEAR;
         cal_month = cda_pkg::MONTHS_PER_YEAR;
         cal_day   = cda_pkg::LONG_MONTH_DAYS;
         st        = cda_pkg::STATUS_OVERFLOW;
      end else if (op == cda_pkg::OP_ADD_MONTHS || op == cda_pkg::OP_ADD_YEARS) begin
         // Clamp the day to the end of the month landed on.
         len = days_of(cal_year, cal_month);
         if (cal_day > len)
            cal_day = len;
      end
      w.year   = cal_year[cda_pkg::YEAR_W-1:0];
      w.month  = cal_month[cda_pkg::MONTH_W-1:0];
      w.day    = cal_day[cda_pkg::DAY_W-1:0];
      w.status = st;
      return w;
   endfunction

   task automatic table_row(input cda_pkg::opcode_type op, input int unsigned y,
                            input int unsigned m, input int unsigned d,
                            input int unsigned amt, input bit known,
                            input int unsigned ey, input int unsigned em,
                            input int unsigned ed, input cda_pkg::status_type est);
      date_cmd_type c;
      c.op          = op;
      c.year        = y[cda_pkg::YEAR_W-1:0];
      c.month       = m[cda_pkg::MONTH_W-1:0];
      c.day         = d[cda_pkg::DAY_W-1:0];
      c.amount      = amt[cda_pkg::AMT_W-1:0];
      c.known       = known;
      c.want.year   = ey[cda_pkg::YEAR_W-1:0];
      c.want.month  = em[cda_pkg::MONTH_W-1:0];
      c.want.day    = ed[cda_pkg::DAY_W-1:0];
      c.want.status = est;
      directed_cmds.push_back(c);
   endtask

   // Present one word from a falling edge, hold it until accepted, then
   // record the expected date. Returns at the falling edge after acceptance.
   task automatic send_word(input date_cmd_type c, input int unsigned idle_pct);
      date_word_type predicted;
      // Idle the sender cycle by cycle at the requested rate.
      while ($urandom_range(0, 99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      req_opcode    = c.op;
      req_new_year  = c.year;
      req_new_month = c.month;
      req_new_day   = c.day;
      req_amount    = c.amount;
      start         = 1'b1;
      // Hold until a rising edge sees busy low.
      @(posedge clock);
      while (busy)
         @(posedge clock);
      predicted = advance_calendar(c.op, c.year, c.month, c.day, c.amount);
      pending_dates.push_back(c.known ? c.want : predicted);
      @(negedge clock);
   endtask

   // Pause the sender until every expected date has come back.
   task automatic drain_dates();
      start = 1'b0;
      while (pending_dates.size() != 0)
         @(negedge clock);
   endtask

   // Check each result strobe against the oldest expected date.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_dates.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result %0d-%0d-%0d status %0d", $time,
                     rsp_cur_year, rsp_cur_month, rsp_cur_day, rsp_status);
         end else begin
            oldest_date = pending_dates.pop_front();
            if (rsp_cur_year !== oldest_date.year || rsp_cur_month !== oldest_date.month ||
                rsp_cur_day !== oldest_date.day || rsp_status !== oldest_date.status) begin
               error_count++;
               $display("%0t: expected %0d-%0d-%0d status %0d, got %0d-%0d-%0d status %0d",
                        $time, oldest_date.year, oldest_date.month, oldest_date.day,
                        oldest_date.status, rsp_cur_year, rsp_cur_month, rsp_cur_day,
                        rsp_status);
            end
         end
      end
   end

   // Drop the run if it hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** calendar_date_adder: FAILED **");
         $finish;
      end
   end

   initial begin : stimulus
      date_cmd_type c;
      int unsigned  idle_levels[3];
      int unsigned  pick;
      int unsigned  shape;
      int unsigned  max_amt;

      error_count   = 0;
      cycle_count   = 0;
      reset         = 1'b1;
      start         = 1'b0;
      req_opcode    = cda_pkg::OP_SET_DATE;
      req_new_year  = '0;
      req_new_month = '0;
      req_new_day   = '0;
      req_amount    = '0;
      cal_year      = cda_pkg::RESET_YEAR;
      cal_month     = cda_pkg::FIRST_MONTH;
      cal_day       = cda_pkg::FIRST_DAY;

      // Directed words: reset date, leap rules, rejects, clamps, overflow, field extremes.
      table_row(cda_pkg::OP_ADD_DAYS,   0, 0, 0, 0,         1, 2000, 1, 1,
                cda_pkg::STATUS_OK);
      table_row(cda_pkg::OP_SET_DATE,   2000, 2, 29, 65535, 1, 2000, 2, 29,
                cda_pkg::STATUS_OK);
      table_row(cda_pkg::OP_SET_DATE,   1900, 2, 29, 0,     1, 2000, 2, 29,
                cda_pkg::STATUS_INVALID);
      table_row(cda_pkg::OP_ADD_YEARS,  0, 0, 0, 1,         1, 2001, 2, 28,
                cda_pkg::STATUS_OK);
      table_row(cda_pkg::OP_SET_DATE,   0, 1, 1, 0,         1, 0, 1, 1,
                cda_pkg::STATUS_OK);
      table_row(cda_pkg::OP_ADD_DAYS,   16383, 15, 31, 65535, 0, 0, 0, 0,
                cda_pkg::STATUS_OK);
      table_row(cda_pkg::OP_ADD_MONTHS, 0, 0, 0, 65535,     0, 0, 0, 0,
                cda_pkg::STATUS_OK);
      table_row(cda_pkg::OP_SET_DATE,   9999, 12, 31, 0,    1, 9999, 12, 31,
                cda_pkg::STATUS_OK);
      table_row(cda_pkg::OP_ADD_DAYS,   0, 0, 0, 1,         1, 9999, 12, 31,
                cda_pkg::STATUS_OVERFLOW);
      table_row(cda_pkg::OP_SET_DATE,   16383, 6, 15, 0,    1, 9999, 12, 31,
                cda_pkg::STATUS_INVALID);
      table_row(cda_pkg::OP_SET_DATE,   2024, 0, 10, 0,     1, 9999, 12, 31,
                cda_pkg::STATUS_INVALID);
      table_row(cda_pkg::OP_SET_DATE,   2024, 15, 31, 0,    1, 9999, 12, 31,
                cda_pkg::STATUS_INVALID);
      table_row(cda_pkg::OP_SET_DATE,   2024, 3, 0, 0,      1, 9999, 12, 31,
                cda_pkg::STATUS_INVALID);
      table_row(cda_pkg::OP_SET_DATE,   2023, 4, 31, 0,     1, 9999, 12, 31,
                cda_pkg::STATUS_INVALID);
      table_row(cda_pkg::OP_SET_DATE,   2000, 1, 31, 0,     1, 2000, 1, 31,
                cda_pkg::STATUS_OK);
      table_row(cda_pkg::OP_ADD_MONTHS, 0, 0, 0, 1,         1, 2000, 2, 29,
                cda_pkg::STATUS_OK);
      table_row(cda_pkg::OP_ADD_MONTHS, 0, 0, 0, 0,         1, 2000, 2, 29,
                cda_pkg::STATUS_OK);
      table_row(cda_pkg::OP_ADD_DAYS,   0, 0, 0, 366,       0, 0, 0, 0,
                cda_pkg::STATUS_OK);
      table_row(cda_pkg::OP_ADD_MONTHS, 0, 0, 0, 65535,     0, 0, 0, 0,
                cda_pkg::STATUS_OK);
      table_row(cda_pkg::OP_SET_DATE,   9999, 1, 31, 0,     1, 9999, 1, 31,
                cda_pkg::STATUS_OK);
      table_row(cda_pkg::OP_ADD_MONTHS, 0, 0, 0, 11,        1, 9999, 12, 31,
                cda_pkg::STATUS_OK);
      table_row(cda_pkg::OP_ADD_MONTHS, 0, 0, 0, 1,         1, 9999, 12, 31,
                cda_pkg::STATUS_OVERFLOW);
      table_row(cda_pkg::OP_SET_DATE,   9998, 12, 31, 0,    1, 9998, 12, 31,
                cda_pkg::STATUS_OK);
      table_row(cda_pkg::OP_ADD_YEARS,  0, 0, 0, 1,         1, 9999, 12, 31,
                cda_pkg::STATUS_OK);
      table_row(cda_pkg::OP_ADD_YEARS,  0, 0, 0, 65535,     1, 9999, 12, 31,
                cda_pkg::STATUS_OVERFLOW);

      // Hold reset, then release it at a falling edge.
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_cmds[i])
         send_word(directed_cmds[i], 0);
      drain_dates();

      // Random phases: no idling, heavy sender idling, light sender idling.
      idle_levels[0] = 0;
      idle_levels[1] = 85;
      idle_levels[2] = 25;
      foreach (idle_levels[p]) begin
         for (int unsigned k = 0; k < WORDS_PER_PHASE; k++) begin
            // Start from noise in every field; unused fields stay random.
            c.known  = 1'b0;
            c.want   = '0;
            c.year   = cda_pkg::YEAR_W'($urandom_range(0, 16383));
            c.month  = cda_pkg::MONTH_W'($urandom_range(0, 15));
            c.day    = cda_pkg::DAY_W'($urandom_range(0, 31));
            c.amount = cda_pkg::AMT_W'($urandom_range(0, 65535));
            pick     = $urandom_range(0, 99);
            if (pick < 25) begin
               c.op = cda_pkg::OP_SET_DATE;
               // Mostly well-formed dates, biased toward the top year.
               if ($urandom_range(0, 99) < 80) begin
                  shape = $urandom_range(0, 99);
                  if (shape < 15)
                     c.year = cda_pkg::YEAR_W'($urandom_range(9990, 9999));
                  else if (shape < 20)
                     c.year = cda_pkg::YEAR_W'($urandom_range(0, 10));
                  else
                     c.year = cda_pkg::YEAR_W'($urandom_range(0, 9999));
                  c.month = cda_pkg::MONTH_W'($urandom_range(1, 12));
                  c.day   = cda_pkg::DAY_W'($urandom_range(1, days_of(c.year, c.month)));
               end
            end else begin
               if (pick < 60)
                  c.op = cda_pkg::OP_ADD_DAYS;
               else if (pick < 80)
                  c.op = cda_pkg::OP_ADD_MONTHS;
               else
                  c.op = cda_pkg::OP_ADD_YEARS;
               // Keep most amounts small so long day walks stay rare.
               shape = $urandom_range(0, 99);
               if (shape < 65)
                  max_amt = 62;
               else if (shape < 85)
                  max_amt = 1500;
               else
                  max_amt = 65535;
               if (shape < 97)
                  c.amount = cda_pkg::AMT_W'($urandom_range(0, max_amt));
               else
                  c.amount = 16'hFFFF;
            end
            send_word(c, idle_levels[p]);
         end
         drain_dates();
      end

      // Let any late strobe show up before judging.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("** calendar_date_adder: PASSED **");
      else
         $display("** calendar_date_adder: FAILED **");
      $finish;
   end

endmodule
